// ===== rtl/infix_expression_evaluator_unit_defines.svh =====
// assertion macros for the infix expression evaluator checker
// no dependencies; included by the checker file only
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define IEE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("iee check failed");

// next-cycle implication, disabled while reset is asserted
`define IEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("iee check failed");

`endif

// ===== rtl/iee_pkg.sv =====
// shared types, constants and helpers for the infix expression evaluator
// no dependencies; used by every module of the block
`default_nettype none

package iee_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int RESULT_WIDTH = 32;
	localparam int DIV_CNT_W = $clog2(VALUE_WIDTH);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_TIMES = 8'h2A;
	localparam logic [7:0] CHAR_DIVIDE = 8'h2F;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef enum logic [2:0] {
		OP_PLUS   = 3'd0,
		OP_MINUS  = 3'd1,
		OP_TIMES  = 3'd2,
		OP_DIVIDE = 3'd3,
		OP_OTHER  = 3'd4
	} op_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic signed [RESULT_WIDTH-1:0] value;
		logic                           divide_by_zero;
	} out_item_t;

	// classified command from front to back
	typedef struct packed {
		logic       is_digit;
		logic [3:0] digit;
		logic       apply;
		op_t        new_op;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic   start;
		value_t dividend;
		value_t divisor;
	} div_req_t;

	typedef struct packed {
		logic   done;
		value_t quotient;
		logic   div_zero;
	} div_rsp_t;

	// zero-extend or truncate the internal value to the result field
	function automatic logic signed [RESULT_WIDTH-1:0] to_result(input value_t v);
		logic [63:0] w;
		w = 64'(v);
		return $signed(w[RESULT_WIDTH-1:0]);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/infix_expression_evaluator_unit.sv =====
// a digit passes the front register and the queue before the back end takes it; an operator goes
// through the apply state, a division also waits on the 32-step divider; the result register loads
// in the final state after the last apply. One digit or skipped space per cycle while in_ready holds;
// the back end takes no new command while an operator or a division is in progress
// reset: arst_n async active low, clears all control and term state; no clearing pass
`default_nettype none

module infix_expression_evaluator_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// character channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire iee_pkg::in_item_t  in_data,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output iee_pkg::out_item_t      out_data
);

	// front to queue transaction
	logic              push_valid;
	logic              push_ready;
	iee_pkg::cmd_t     push_cmd;

	// queue to back transaction
	logic              pop_valid;
	logic              pop_ready;
	iee_pkg::cmd_t     pop_cmd;

	// divider handshake
	iee_pkg::div_req_t div_req;
	iee_pkg::div_rsp_t div_rsp;

	// front: classifies each character, white space that is not final never leaves it
	iee_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// short queue so the front keeps taking digits while the back divides
	iee_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// back: running sum plus top term, result register on the output side
	iee_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// divider for the divide operator, zero divisor gives quotient 0 and a flag
	iee_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

`default_nettype wire

// ===== rtl/iee_front.sv =====
// front end: takes characters, classifies them and drops plain white space
// depends on iee_pkg
`default_nettype none

module iee_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire iee_pkg::in_item_t in_data,
	output logic                  push_valid,
	input  wire logic             push_ready,
	output iee_pkg::cmd_t         push_cmd
);

	logic          valid_s1;
	iee_pkg::cmd_t cmd_s1;
	iee_pkg::cmd_t cmd;
	iee_pkg::op_t  op;
	logic          is_digit;
	logic          is_space;
	logic          keep;
	logic [7:0]    c;

	assign c = in_data.char_code;
	assign is_digit = (c >= iee_pkg::CHAR_ZERO) && (c <= iee_pkg::CHAR_NINE);
	assign is_space = (c == iee_pkg::CHAR_SPACE) ||
		((c >= iee_pkg::CHAR_TAB) && (c <= iee_pkg::CHAR_CR));

	always_comb begin
		case (c)
			iee_pkg::CHAR_PLUS:   op = iee_pkg::OP_PLUS;
			iee_pkg::CHAR_MINUS:  op = iee_pkg::OP_MINUS;
			iee_pkg::CHAR_TIMES:  op = iee_pkg::OP_TIMES;
			iee_pkg::CHAR_DIVIDE: op = iee_pkg::OP_DIVIDE;
			default:              op = iee_pkg::OP_OTHER;
		endcase
	end

	// white space that is not final has no effect at all
	assign keep = !is_space || is_digit || in_data.last_char;

	always_comb begin
		cmd.is_digit = is_digit;
		cmd.digit = 4'(c - iee_pkg::CHAR_ZERO);
		cmd.apply = !is_digit || in_data.last_char;
		cmd.new_op = op;
		cmd.last = in_data.last_char;
	end

	assign in_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/iee_queue.sv =====
// short command queue between front and back
// depends on iee_pkg
`default_nettype none

module iee_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire iee_pkg::cmd_t push_cmd,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output iee_pkg::cmd_t      pop_cmd
);

	iee_pkg::cmd_t                entry_q [iee_pkg::QUEUE_DEPTH];
	logic [iee_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [iee_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [iee_pkg::QCNT_W-1:0]   count_q;
	logic                         do_push;
	logic                         do_pop;

	assign push_ready = count_q != iee_pkg::QCNT_W'(iee_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/iee_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on iee_pkg
`default_nettype none

module iee_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire iee_pkg::div_req_t req,
	output iee_pkg::div_rsp_t      rsp
);

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_SIGN,
		D_DONE
	} dstate_t;

	dstate_t                         state_q;
	iee_pkg::value_t                 rem_q;
	iee_pkg::value_t                 quo_q;
	iee_pkg::value_t                 den_q;
	logic                            neg_q;
	logic                            dz_q;
	logic [iee_pkg::DIV_CNT_W-1:0]   cnt_q;

	logic [iee_pkg::VALUE_WIDTH:0]   rem_sh;
	logic [iee_pkg::VALUE_WIDTH:0]   rem_sub;
	logic                            fits;
	iee_pkg::value_t                 mag_a;
	iee_pkg::value_t                 mag_b;

	assign mag_a = req.dividend[iee_pkg::VALUE_WIDTH-1] ? -req.dividend : req.dividend;
	assign mag_b = req.divisor[iee_pkg::VALUE_WIDTH-1] ? -req.divisor : req.divisor;

	assign rem_sh = {rem_q, quo_q[iee_pkg::VALUE_WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits = rem_sh >= {1'b0, den_q};

	assign rsp.done = state_q == D_DONE;
	assign rsp.quotient = quo_q;
	assign rsp.div_zero = dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			neg_q <= 1'b0;
			dz_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						rem_q <= '0;
						cnt_q <= '0;
						if (req.divisor == '0) begin
							quo_q <= '0;
							dz_q <= 1'b1;
							state_q <= D_DONE;
						end else begin
							quo_q <= mag_a;
							den_q <= mag_b;
							neg_q <= req.dividend[iee_pkg::VALUE_WIDTH-1] ^
								req.divisor[iee_pkg::VALUE_WIDTH-1];
							dz_q <= 1'b0;
							state_q <= D_RUN;
						end
					end
				end
				D_RUN: begin
					// restoring step, quotient bits shift in behind the dividend
					rem_q <= fits ? rem_sub[iee_pkg::VALUE_WIDTH-1:0]
						: rem_sh[iee_pkg::VALUE_WIDTH-1:0];
					quo_q <= {quo_q[iee_pkg::VALUE_WIDTH-2:0], fits};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == iee_pkg::DIV_CNT_W'(iee_pkg::VALUE_WIDTH - 1)) begin
						state_q <= D_SIGN;
					end
				end
				D_SIGN: begin
					quo_q <= neg_q ? -quo_q : quo_q;
					state_q <= D_DONE;
				end
				D_DONE: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/iee_back.sv =====
// back end: number build, operator apply, term bookkeeping and result register
// depends on iee_pkg; drives the iee_div unit through a request struct
`default_nettype none

module iee_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire iee_pkg::cmd_t     cmd,
	output iee_pkg::div_req_t      div_req,
	input  wire iee_pkg::div_rsp_t div_rsp,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output iee_pkg::out_item_t     out_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t             state_q;
	iee_pkg::value_t    psum_q;
	iee_pkg::value_t    top_q;
	iee_pkg::value_t    cur_q;
	iee_pkg::op_t       pend_q;
	iee_pkg::op_t       next_op_q;
	logic               last_q;
	logic               err_q;
	logic               out_valid_q;
	iee_pkg::out_item_t out_q;

	iee_pkg::value_t    cur_next;
	iee_pkg::value_t    prod;
	logic               out_free;

	assign cur_next = (cur_q << 3) + (cur_q << 1) + iee_pkg::VALUE_WIDTH'(cmd.digit);
	assign prod = top_q * cur_q;
	assign out_free = !out_valid_q || out_ready;

	assign cmd_ready = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		div_req.start = (state_q == ST_EXEC) && (pend_q == iee_pkg::OP_DIVIDE);
		div_req.dividend = top_q;
		div_req.divisor = cur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			psum_q <= '0;
			top_q <= '0;
			cur_q <= '0;
			pend_q <= iee_pkg::OP_PLUS;
			next_op_q <= iee_pkg::OP_PLUS;
			last_q <= 1'b0;
			err_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			// the final state reloads the result register itself
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.is_digit) begin
							cur_q <= cur_next;
						end
						if (cmd.apply) begin
							next_op_q <= cmd.new_op;
							last_q <= cmd.last;
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					case (pend_q)
						iee_pkg::OP_PLUS: begin
							psum_q <= psum_q + top_q;
							top_q <= cur_q;
						end
						iee_pkg::OP_MINUS: begin
							psum_q <= psum_q + top_q;
							top_q <= -cur_q;
						end
						iee_pkg::OP_TIMES: begin
							top_q <= prod;
						end
						default: begin
						end
					endcase
					if (pend_q == iee_pkg::OP_DIVIDE) begin
						state_q <= ST_DIV;
					end else begin
						cur_q <= '0;
						pend_q <= next_op_q;
						state_q <= last_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						top_q <= div_rsp.quotient;
						err_q <= err_q | div_rsp.div_zero;
						cur_q <= '0;
						pend_q <= next_op_q;
						state_q <= last_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q.value <= iee_pkg::to_result(psum_q + top_q);
						out_q.divide_by_zero <= err_q;
						psum_q <= '0;
						top_q <= '0;
						cur_q <= '0;
						pend_q <= iee_pkg::OP_PLUS;
						err_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/iee_checker.sv =====
// port-level checker for the infix expression evaluator, bound to the top level
// depends on iee_pkg and infix_expression_evaluator_unit_defines.svh
`default_nettype none
`include "infix_expression_evaluator_unit_defines.svh"

module iee_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire iee_pkg::in_item_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire iee_pkg::out_item_t out_data
);

	// a stalled result stays offered and unchanged
	`IEE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`IEE_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data))
	// leaving reset: no stale result, front ready for the first character
	`IEE_ASSERT_IMP(a_rst_no_out, clk, arst_n, $rose(arst_n), !out_valid)
	`IEE_ASSERT_IMP(a_rst_ready, clk, arst_n, $rose(arst_n), in_ready)
	// an offered character carries a known payload
	`IEE_ASSERT_IMP(a_in_known, clk, arst_n, in_valid, !$isunknown(in_data))

endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (.*);

`default_nettype wire
